// ===== rtl/tsd_pkg.sv =====
// shared types and constants for the touch swipe detector
// no dependencies; imported by every module of the block
package tsd_pkg;

   // event kinds carried in the request tuser
   localparam logic [1:0] OP_DOWN = 2'd0;
   localparam logic [1:0] OP_MOVE = 2'd1;
   localparam logic [1:0] OP_LIFT = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   // reported swipe directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // latched direction codes
   localparam logic [2:0] LATCH_NONE  = 3'd0;
   localparam logic [2:0] LATCH_UP    = 3'd1;
   localparam logic [2:0] LATCH_DOWN  = 3'd2;
   localparam logic [2:0] LATCH_LEFT  = 3'd3;
   localparam logic [2:0] LATCH_RIGHT = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_X_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_Y_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_PAUSE_TICKS = 2'd2;
   localparam logic [1:0] CSR_DIR_ENABLE  = 2'd3;

   localparam int POS_W   = 10;
   localparam int TICKS_W = 16;

   // register reset values
   localparam logic [POS_W-1:0]   RST_X_THRESHOLD = 10'd20;
   localparam logic [POS_W-1:0]   RST_Y_THRESHOLD = 10'd20;
   localparam logic [TICKS_W-1:0] RST_PAUSE_TICKS = 16'd100;
   localparam logic [3:0]         RST_DIR_ENABLE  = 4'hf;

   typedef struct packed {
      logic [POS_W-1:0]   x_threshold;
      logic [POS_W-1:0]   y_threshold;
      logic [TICKS_W-1:0] pause_ticks;
      logic [3:0]         direction_enable;
   } cfg_type;

   typedef struct packed {
      logic       swipe_valid;
      logic [1:0] swipe_dir;
      logic       is_paused;
   } result_type;

endpackage

// ===== rtl/tsd_csr.sv =====
// configuration registers of the touch swipe detector
// depends on tsd_pkg for register indexes, reset values and cfg_type
module tsd_csr
   import tsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [TICKS_W-1:0]  csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_X_THRESHOLD: cfg_in.x_threshold      = csr_wdata[POS_W-1:0];
            CSR_Y_THRESHOLD: cfg_in.y_threshold      = csr_wdata[POS_W-1:0];
            CSR_PAUSE_TICKS: cfg_in.pause_ticks      = csr_wdata;
            CSR_DIR_ENABLE:  cfg_in.direction_enable = csr_wdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_threshold      <= RST_X_THRESHOLD;
         cfg_ff.y_threshold      <= RST_Y_THRESHOLD;
         cfg_ff.pause_ticks      <= RST_PAUSE_TICKS;
         cfg_ff.direction_enable <= RST_DIR_ENABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tsd_core.sv =====
// gesture state and per-event update of the touch swipe detector
// depends on tsd_pkg; result is combinational, state updates on fire
module tsd_core
   import tsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [1:0]         op,
   input  logic [POS_W-1:0]   pos_x,
   input  logic [POS_W-1:0]   pos_y,
   input  cfg_type            cfg,
   output result_type         result
);

   logic [POS_W-1:0]   ref_x_ff, ref_x_in;
   logic [POS_W-1:0]   ref_y_ff, ref_y_in;
   logic [2:0]         latched_ff, latched_in;
   logic               paused_ff, paused_in;
   logic [TICKS_W-1:0] count_ff, count_in;

   logic [POS_W:0] y_lim_up, y_lim_down, x_lim_left, x_lim_right;
   logic           hit_up, hit_down, hit_left, hit_right;
   logic           latch_en;
   logic [1:0]     latch_dir;

   // strict threshold crossings, as unsigned compares on widened sums
   assign y_lim_up    = {1'b0, pos_y}    + {1'b0, cfg.y_threshold};
   assign y_lim_down  = {1'b0, ref_y_ff} + {1'b0, cfg.y_threshold};
   assign x_lim_left  = {1'b0, pos_x}    + {1'b0, cfg.x_threshold};
   assign x_lim_right = {1'b0, ref_x_ff} + {1'b0, cfg.x_threshold};

   assign hit_up    = cfg.direction_enable[DIR_UP]    && ({1'b0, ref_y_ff} > y_lim_up);
   assign hit_down  = cfg.direction_enable[DIR_DOWN]  && ({1'b0, pos_y} > y_lim_down);
   assign hit_left  = cfg.direction_enable[DIR_LEFT]  && ({1'b0, ref_x_ff} > x_lim_left);
   assign hit_right = cfg.direction_enable[DIR_RIGHT] && ({1'b0, pos_x} > x_lim_right);

   // map the latched code to a direction and its enable, re-checked at liftoff
   always_comb begin
      unique case (latched_ff)
         LATCH_UP: begin
            latch_dir = DIR_UP;
            latch_en  = cfg.direction_enable[DIR_UP];
         end
         LATCH_DOWN: begin
            latch_dir = DIR_DOWN;
            latch_en  = cfg.direction_enable[DIR_DOWN];
         end
         LATCH_LEFT: begin
            latch_dir = DIR_LEFT;
            latch_en  = cfg.direction_enable[DIR_LEFT];
         end
         LATCH_RIGHT: begin
            latch_dir = DIR_RIGHT;
            latch_en  = cfg.direction_enable[DIR_RIGHT];
         end
         default: begin
            latch_dir = DIR_UP;
            latch_en  = 1'b0;
         end
      endcase
   end

   // next state and result for the current event
   always_comb begin
      ref_x_in           = ref_x_ff;
      ref_y_in           = ref_y_ff;
      latched_in         = latched_ff;
      paused_in          = paused_ff;
      count_in           = count_ff;
      result.swipe_valid = 1'b0;
      result.swipe_dir   = DIR_UP;
      unique case (op)
         OP_DOWN: begin
            if (!paused_ff) begin
               ref_x_in   = pos_x;
               ref_y_in   = pos_y;
               latched_in = LATCH_NONE;
            end
         end
         OP_MOVE: begin
            if (!paused_ff && latched_ff == LATCH_NONE) begin
               if (hit_up) begin
                  latched_in = LATCH_UP;
                  ref_y_in   = pos_y;
               end else if (hit_down) begin
                  latched_in = LATCH_DOWN;
                  ref_y_in   = pos_y;
               end else if (hit_left) begin
                  latched_in = LATCH_LEFT;
                  ref_x_in   = pos_x;
               end else if (hit_right) begin
                  latched_in = LATCH_RIGHT;
                  ref_x_in   = pos_x;
               end
            end
         end
         OP_LIFT: begin
            if (!paused_ff) begin
               paused_in = 1'b1;
               count_in  = cfg.pause_ticks;
            end
            result.swipe_valid = latch_en;
            result.swipe_dir   = latch_en ? latch_dir : DIR_UP;
            latched_in         = LATCH_NONE;
         end
         OP_TICK: begin
            if (paused_ff) begin
               if (count_ff <= TICKS_W'(1)) begin
                  count_in  = '0;
                  paused_in = 1'b0;
               end else begin
                  count_in = count_ff - TICKS_W'(1);
               end
            end
         end
         default: begin
            latched_in = latched_ff;
         end
      endcase
      result.is_paused = paused_in;
   end

   // gesture state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff   <= '0;
         ref_y_ff   <= '0;
         latched_ff <= LATCH_NONE;
         paused_ff  <= 1'b1;
         count_ff   <= RST_PAUSE_TICKS;
      end else if (fire) begin
         ref_x_ff   <= ref_x_in;
         ref_y_ff   <= ref_y_in;
         latched_ff <= latched_in;
         paused_ff  <= paused_in;
         count_ff   <= count_in;
      end
   end

   // a liftoff always leaves the block paused
   a_lift_pauses: assert property (@(posedge clock) disable iff (reset)
      fire && op == OP_LIFT |=> paused_ff)
      else $error("liftoff did not leave the block paused");

   // the pause only ends on a tick
   a_pause_ends_on_tick: assert property (@(posedge clock) disable iff (reset)
      $fell(paused_ff) |-> $past(fire && op == OP_TICK))
      else $error("pause ended without a tick");

   // a direction only latches on an update while unpaused
   a_latch_on_move: assert property (@(posedge clock) disable iff (reset)
      fire && latched_ff == LATCH_NONE && latched_in != LATCH_NONE
      |-> op == OP_MOVE && !paused_ff)
      else $error("direction latched outside an unpaused update");

   // a reported swipe comes from a liftoff with a latched direction
   a_swipe_from_latch: assert property (@(posedge clock) disable iff (reset)
      fire && result.swipe_valid |-> op == OP_LIFT && latched_ff != LATCH_NONE)
      else $error("swipe reported without a latched direction");

endmodule

// ===== rtl/touch_swipe_detector.sv =====
// top level of the touch swipe detector: request and response registers
// depends on tsd_pkg, tsd_csr and tsd_core
//
//  channel  | dir | tdata (low bit up)              | tuser        | handshake
//  req_     | in  | pos_x[9:0], pos_y[19:10], pad   | op[1:0]      | tvalid/tready
//  rsp_     | out | swipe_dir[1:0], is_paused[2]    | swipe_valid  | tvalid/tready
//  csr_     | in  | wdata[15:0] to register addr    | -            | we, no wait
//
// one request accepted per cycle unless the response is stalled; each gives
// exactly one response, via the request register, then the response register
// the gesture state is updated as a request leaves the request register
// a stalled response holds the response register; the request register
// then fills and req_tready drops until rsp_tready returns
// reset clears the gesture state to paused and the registers to their defaults
module touch_swipe_detector
   import tsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // pos_x[9:0], pos_y[19:10], zero pad
   input  logic [1:0]          req_tuser,   // op[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // swipe_dir[1:0], is_paused[2], zero pad
   output logic                rsp_tuser,   // swipe_valid
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [TICKS_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic             req_valid_ff;
   logic [1:0]       req_op_ff;
   logic [POS_W-1:0] req_x_ff;
   logic [POS_W-1:0] req_y_ff;
   logic             rsp_valid_ff;
   result_type       rsp_ff;
   logic             fire;
   logic             req_take;

   // request moves on when the response register is free or being emptied
   assign fire       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_op_ff <= req_tuser;
         req_x_ff  <= req_tdata[POS_W-1:0];
         req_y_ff  <= req_tdata[2*POS_W-1:POS_W];
      end
   end

   tsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .op     (req_op_ff),
      .pos_x  (req_x_ff),
      .pos_y  (req_y_ff),
      .cfg    (cfg),
      .result (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.swipe_valid;
   assign rsp_tdata  = {5'b0, rsp_ff.is_paused, rsp_ff.swipe_dir};

endmodule

// ===== tb/sv/swipe_checker.sv =====
// checker for the touch swipe detector: watches the request, response and
// register channels, predicts every response and compares it field by field
// depends on tsd_pkg
module swipe_checker
   import tsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [23:0]        req_tdata,   // pos_x[9:0], pos_y[19:10], zero pad
   input  logic [1:0]         req_tuser,   // op[1:0]
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [7:0]         rsp_tdata,   // swipe_dir[1:0], is_paused[2], zero pad
   input  logic               rsp_tuser,   // swipe_valid
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [TICKS_W-1:0] csr_wdata,
   output int                 mismatches,
   output int                 pending,
   output int                 swipes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the registers and the gesture state
   cfg_type            cfg;
   logic [POS_W-1:0]   anchor_x;
   logic [POS_W-1:0]   anchor_y;
   logic [2:0]         held_dir;
   logic               in_pause;
   logic [TICKS_W-1:0] pause_left;

   // responses still owed by the block, oldest first
   result_type expected_results[$];

   // advance the gesture state by one event and work out its response
   task automatic apply_touch_event(input logic [1:0] op, input logic [POS_W-1:0] px,
                                    input logic [POS_W-1:0] py, output result_type res);
      int         dx;
      int         dy;
      logic [1:0] dir;
      res = '0;
      dx  = int'(px) - int'(anchor_x);
      dy  = int'(py) - int'(anchor_y);
      case (op)
         OP_DOWN: begin
            if (!in_pause) begin
               anchor_x = px;
               anchor_y = py;
               held_dir = LATCH_NONE;
            end
         end
         OP_MOVE: begin
            // first strict crossing in the order up, down, left, right
            if (!in_pause && held_dir == LATCH_NONE) begin
               if (cfg.direction_enable[DIR_UP] && dy < -int'(cfg.y_threshold)) begin
                  held_dir = LATCH_UP;
                  anchor_y = py;
               end else if (cfg.direction_enable[DIR_DOWN] && dy > int'(cfg.y_threshold)) begin
                  held_dir = LATCH_DOWN;
                  anchor_y = py;
               end else if (cfg.direction_enable[DIR_LEFT] && dx < -int'(cfg.x_threshold)) begin
                  held_dir = LATCH_LEFT;
                  anchor_x = px;
               end else if (cfg.direction_enable[DIR_RIGHT] && dx > int'(cfg.x_threshold)) begin
                  held_dir = LATCH_RIGHT;
                  anchor_x = px;
               end
            end
         end
         OP_LIFT: begin
            // a liftoff inside a pause leaves the count running
            if (!in_pause) begin
               in_pause   = 1'b1;
               pause_left = cfg.pause_ticks;
            end
            // the enable is looked at again when the swipe is reported
            if (held_dir != LATCH_NONE && held_dir <= LATCH_RIGHT) begin
               dir = 2'(held_dir - LATCH_UP);
               if (cfg.direction_enable[dir]) begin
                  res.swipe_valid = 1'b1;
                  res.swipe_dir   = dir;
               end
            end
            held_dir = LATCH_NONE;
         end
         default: begin
            // tick: a count of zero behaves like one
            if (in_pause) begin
               if (pause_left <= 1) begin
                  pause_left = '0;
                  in_pause   = 1'b0;
               end else begin
                  pause_left = pause_left - 1'b1;
               end
            end
         end
      endcase
      res.is_paused = in_pause;
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // sample every channel at the clock edge
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cfg.x_threshold      = RST_X_THRESHOLD;
         cfg.y_threshold      = RST_Y_THRESHOLD;
         cfg.pause_ticks      = RST_PAUSE_TICKS;
         cfg.direction_enable = RST_DIR_ENABLE;
         anchor_x             = '0;
         anchor_y             = '0;
         held_dir             = LATCH_NONE;
         in_pause             = 1'b1;
         pause_left           = RST_PAUSE_TICKS;
         expected_results.delete();
         mismatches           = 0;
         swipes_seen          = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               CSR_X_THRESHOLD: cfg.x_threshold      = csr_wdata[POS_W-1:0];
               CSR_Y_THRESHOLD: cfg.y_threshold      = csr_wdata[POS_W-1:0];
               CSR_PAUSE_TICKS: cfg.pause_ticks      = csr_wdata;
               default:         cfg.direction_enable = csr_wdata[3:0];
            endcase
         end
         // response side
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, actual %b/%b",
                        $time, rsp_tuser, rsp_tdata[2:0]);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("swipe_valid", want.swipe_valid, rsp_tuser);
               check_field("swipe_dir", want.swipe_dir, rsp_tdata[1:0]);
               check_field("is_paused", want.is_paused, rsp_tdata[2]);
               if (want.swipe_valid) swipes_seen++;
            end
         end
         // request side
         if (req_tvalid && req_tready) begin
            apply_touch_event(req_tuser, req_tdata[POS_W-1:0], req_tdata[2*POS_W-1:POS_W], want);
            expected_results.push_back(want);
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the touch swipe detector testbench: clock, reset, stimulus and verdict
// depends on tsd_pkg, touch_swipe_detector and swipe_checker
module tb_top;
   import tsd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 850;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [23:0]        req_tdata;   // pos_x[9:0], pos_y[19:10], zero pad
   logic [1:0]         req_tuser;   // op[1:0]
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [7:0]         rsp_tdata;   // swipe_dir[1:0], is_paused[2], zero pad
   logic               rsp_tuser;   // swipe_valid
   logic               csr_we;
   logic [1:0]         csr_addr;
   logic [TICKS_W-1:0] csr_wdata;

   int   mismatches;
   int   pending;
   int   swipes_seen;
   int   items_sent;
   int   settings_used;
   int   quiet_cycles;
   bit   req_idling;
   logic rsp_idling;
   logic hold_req;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   touch_swipe_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   swipe_checker swipe_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .pending     (pending),
      .swipes_seen (swipes_seen)
   );

   // response side: random back-pressure, a free-running stretch and one long hold-off
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idling) begin
            rsp_tready <= ($urandom_range(99) >= 38);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // offer one request, with random idle cycles ahead of it
   task automatic send_event(input logic [1:0] op, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py);
      while (req_idling && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // stop offering and wait until every response is back
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // write all four registers back to back
   task automatic write_config(input logic [POS_W-1:0] xt, input logic [POS_W-1:0] yt,
                               input logic [TICKS_W-1:0] pt, input logic [3:0] en);
      logic [1:0]         idx[4];
      logic [TICKS_W-1:0] val[4];
      idx = '{CSR_X_THRESHOLD, CSR_Y_THRESHOLD, CSR_PAUSE_TICKS, CSR_DIR_ENABLE};
      val = '{TICKS_W'(xt), TICKS_W'(yt), pt, TICKS_W'(en)};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // a coordinate near the base: jitter, just either side of the threshold, or anywhere
   function automatic logic [POS_W-1:0] offset_pos(input logic [POS_W-1:0] base,
                                                   input logic [POS_W-1:0] thr);
      int v;
      case ($urandom_range(3))
         0:       v = int'(base) + int'($urandom_range(6)) - 3;
         1:       v = int'(base) + int'(thr) + int'($urandom_range(3)) - 1;
         2:       v = int'(base) - int'(thr) - int'($urandom_range(3)) + 1;
         default: v = int'($urandom_range(1023));
      endcase
      if (v < 0) v = 0;
      else if (v > 1023) v = 1023;
      return v[POS_W-1:0];
   endfunction

   // touchdown, a few moves, liftoff, then ticks to sit out the pause
   task automatic run_gesture(input logic [POS_W-1:0] xt, input logic [POS_W-1:0] yt,
                              input logic [TICKS_W-1:0] pt);
      logic [POS_W-1:0] x0;
      logic [POS_W-1:0] y0;
      int               n_ticks;
      // occasional noise ahead of the gesture
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 3))
            send_event(2'($urandom_range(3)), 10'($urandom_range(1023)),
                       10'($urandom_range(1023)));
      end
      x0 = 10'($urandom_range(1023));
      y0 = 10'($urandom_range(1023));
      send_event(OP_DOWN, x0, y0);
      repeat ($urandom_range(1, 4)) send_event(OP_MOVE, offset_pos(x0, xt), offset_pos(y0, yt));
      send_event(OP_LIFT, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      // now and then cut the pause short so the next touchdown is ignored
      n_ticks = ($urandom_range(9) == 0) ? int'($urandom_range(pt)) : int'(pt) + 1;
      repeat (n_ticks) send_event(OP_TICK, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
   endtask

   initial begin
      logic [POS_W-1:0]   xt;
      logic [POS_W-1:0]   yt;
      logic [TICKS_W-1:0] pt;
      logic [3:0]         en;
      int                 phase;
      int                 random_end;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_TICK;
      csr_we        = 1'b0;
      csr_addr      = CSR_X_THRESHOLD;
      csr_wdata     = '0;
      req_idling    = 1'b1;
      rsp_idling    = 1'b1;
      hold_req      = 1'b0;
      items_sent    = 0;
      settings_used = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out of reset the block is paused: touchdown, move and liftoff are ignored
      send_event(OP_DOWN, 10'd100, 10'd100);
      send_event(OP_MOVE, 10'd100, 10'd0);
      send_event(OP_LIFT, 10'd0, 10'd0);
      repeat (RST_PAUSE_TICKS) send_event(OP_TICK, 10'd1023, 10'd1023);
      // tick while not paused
      send_event(OP_TICK, 10'd0, 10'd0);

      // movement of exactly the threshold does not count; a zero pause ends on one tick
      wait_for_responses();
      write_config(10'd20, 10'd20, 16'd0, 4'hf);
      send_event(OP_DOWN, 10'd512, 10'd512);
      send_event(OP_MOVE, 10'd512, 10'd492);
      send_event(OP_MOVE, 10'd512, 10'd491);
      send_event(OP_MOVE, 10'd0, 10'd1023);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);

      // zero thresholds, a one-step move right and full-range movement up, down and left
      wait_for_responses();
      write_config(10'd0, 10'd0, 16'd1, 4'hf);
      send_event(OP_DOWN, 10'd0, 10'd0);
      send_event(OP_MOVE, 10'd1, 10'd0);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);
      send_event(OP_DOWN, 10'd1023, 10'd1023);
      send_event(OP_MOVE, 10'd0, 10'd1023);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);
      send_event(OP_DOWN, 10'd0, 10'd0);
      send_event(OP_MOVE, 10'd0, 10'd1023);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);
      send_event(OP_DOWN, 10'd1023, 10'd1023);
      send_event(OP_MOVE, 10'd1023, 10'd0);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);
      // a second touchdown clears the latched direction
      send_event(OP_DOWN, 10'd0, 10'd0);
      send_event(OP_MOVE, 10'd0, 10'd1);
      send_event(OP_DOWN, 10'd0, 10'd0);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);

      // widest thresholds with every direction off
      wait_for_responses();
      write_config(10'd1023, 10'd1023, 16'd1, 4'h0);
      send_event(OP_DOWN, 10'd0, 10'd0);
      send_event(OP_MOVE, 10'd1023, 10'd1023);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);

      // latched direction disabled before the liftoff reports it
      wait_for_responses();
      write_config(10'd1023, 10'd10, 16'd1, 4'h2);
      send_event(OP_DOWN, 10'd0, 10'd0);
      send_event(OP_MOVE, 10'd0, 10'd100);
      wait_for_responses();
      write_config(10'd1023, 10'd10, 16'd1, 4'h1);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);

      // random gestures, a fresh register setting per phase
      random_end = items_sent + RANDOM_ITEMS;
      phase      = 0;
      while (items_sent < random_end) begin
         xt = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(40));
         yt = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(40));
         pt = 16'($urandom_range(6));
         en = ($urandom_range(1) == 1) ? 4'hf : 4'($urandom_range(15));
         wait_for_responses();
         write_config(xt, yt, pt, en);
         req_idling = (phase != 1 && phase != 3);
         rsp_idling <= (phase != 3);
         // long response hold-off while requests keep coming
         if (phase == 1) hold_req <= 1'b1;
         repeat (20) run_gesture(xt, yt, pt);
         phase++;
      end
      req_idling = 1'b1;
      rsp_idling <= 1'b1;

      // longest pause setting: a run of ticks leaves it far from its end
      repeat (8) send_event(OP_TICK, 10'd0, 10'd0);
      wait_for_responses();
      write_config(10'd20, 10'd20, 16'hffff, 4'hf);
      send_event(OP_DOWN, 10'd300, 10'd300);
      send_event(OP_MOVE, 10'd300, 10'd400);
      send_event(OP_LIFT, 10'd300, 10'd400);
      repeat (40) send_event(OP_TICK, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      send_event(OP_DOWN, 10'd700, 10'd700);
      send_event(OP_MOVE, 10'd600, 10'd700);
      send_event(OP_LIFT, 10'd0, 10'd0);
      send_event(OP_TICK, 10'd0, 10'd0);

      // drain, let the pipeline settle and give the verdict
      wait_for_responses();
      repeat (4) @(posedge clock);
      @(negedge clock);
      $display("covered %0d touch events under %0d register settings, %0d swipes reported,",
               items_sent, settings_used, swipes_seen);
      $display("with a long response hold-off and the widest pause setting loaded");
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tsd_pkg.sv
rtl/tsd_csr.sv
rtl/tsd_core.sv
rtl/touch_swipe_detector.sv
tb/sv/swipe_checker.sv
tb/sv/tb_top.sv
